/* rtl/tcc_pkg.sv */
// shared types and constants for the text console cursor unit
// no dependencies
`default_nettype none

package tcc_pkg;

  localparam logic [7:0] CH_BS    = 8'd8;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  localparam logic KIND_DRAW   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAB_WIDTH   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOUR   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BG_COLOUR   = 3'd6;

  typedef struct packed {
    logic [8:0]  columns;
    logic [8:0]  rows;
    logic [5:0]  cell_width;
    logic [5:0]  cell_height;
    logic [6:0]  tab_width;
    logic [31:0] fg_colour;
    logic [31:0] bg_colour;
  } cfg_t;

  // one classified character: an optional draw followed by an optional scroll
  typedef struct packed {
    logic       has_draw;
    logic       has_scroll;
    logic [7:0] glyph;
    logic [7:0] col;
    logic [7:0] row;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/tcc_front.sv */
// front end: cursor state and classification of each character
// depends on tcc_pkg
`default_nettype none

module tcc_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tcc_pkg::cfg_t cfg,
  input  wire logic          accept,
  input  wire logic [7:0]    char_code,
  output logic               cmd_valid,
  output tcc_pkg::cmd_t      cmd
);

  logic [7:0] col_r, col_nxt;
  logic [7:0] row_r, row_nxt;

  logic [8:0] ncol;
  logic [8:0] nrow;
  logic [6:0] tw;
  logic [8:0] tab_col;
  logic [8:0] inc_col;
  logic [8:0] inc_row;
  logic       nl_scroll;
  logic [7:0] nl_row;

  always_comb begin
    if (cfg.columns == 9'd0) ncol = 9'd1;
    else if (cfg.columns > 9'd256) ncol = 9'd256;
    else ncol = cfg.columns;
    if (cfg.rows == 9'd0) nrow = 9'd1;
    else if (cfg.rows > 9'd256) nrow = 9'd256;
    else nrow = cfg.rows;
    if (cfg.tab_width == 7'd0) tw = 7'd1;
    else if (cfg.tab_width > 7'd64) tw = 7'd64;
    else tw = cfg.tab_width;
  end

  assign tab_col = ({1'b0, col_r} + {2'b00, tw}) & ~({2'b00, tw} - 9'd1);
  assign inc_col = {1'b0, col_r} + 9'd1;
  assign inc_row = {1'b0, row_r} + 9'd1;

  // new line target
  always_comb begin
    nl_scroll = (inc_row >= nrow);
    if (nl_scroll) nl_row = 8'(nrow - 9'd1);
    else nl_row = inc_row[7:0];
  end

  always_comb begin
    col_nxt        = col_r;
    row_nxt        = row_r;
    cmd.has_draw   = 1'b0;
    cmd.has_scroll = 1'b0;
    cmd.glyph      = char_code;
    cmd.col        = col_r;
    cmd.row        = row_r;
    unique case (char_code)
      tcc_pkg::CH_NL: begin
        col_nxt        = 8'd0;
        row_nxt        = nl_row;
        cmd.has_scroll = nl_scroll;
      end
      tcc_pkg::CH_CR: begin
        col_nxt = 8'd0;
      end
      tcc_pkg::CH_BS: begin
        cmd.has_draw = 1'b1;
        cmd.glyph    = tcc_pkg::CH_SPACE;
        if (col_r != 8'd0) col_nxt = col_r - 8'd1;
      end
      tcc_pkg::CH_TAB: begin
        if (tab_col >= ncol) begin
          col_nxt        = 8'd0;
          row_nxt        = nl_row;
          cmd.has_scroll = nl_scroll;
        end else begin
          col_nxt = tab_col[7:0];
        end
      end
      default: begin
        cmd.has_draw = 1'b1;
        if (inc_col >= ncol) begin
          col_nxt        = 8'd0;
          row_nxt        = nl_row;
          cmd.has_scroll = nl_scroll;
        end else begin
          col_nxt = inc_col[7:0];
        end
      end
    endcase
  end

  assign cmd_valid = accept && (cmd.has_draw || cmd.has_scroll);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= 8'd0;
      row_r <= 8'd0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/tcc_fifo.sv */
// short command queue between front end and back end
// depends on tcc_pkg
`default_nettype none

module tcc_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          wr_en,
  input  wire tcc_pkg::cmd_t wr_data,
  input  wire logic          rd_en,
  output tcc_pkg::cmd_t      rd_data,
  output logic               q_empty,
  output logic               q_full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tcc_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_empty = (count_r == '0);
  assign q_full  = (count_r == CNT_W'(DEPTH));
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      if (wr_ptr_r == PTR_W'(DEPTH - 1)) wr_ptr_nxt = '0;
      else wr_ptr_nxt = wr_ptr_r + PTR_W'(1);
    end
    if (rd_en) begin
      if (rd_ptr_r == PTR_W'(DEPTH - 1)) rd_ptr_nxt = '0;
      else rd_ptr_nxt = rd_ptr_r + PTR_W'(1);
    end
    if (wr_en && !rd_en) count_nxt = count_r + CNT_W'(1);
    else if (!wr_en && rd_en) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wr_ptr_r] <= wr_data;
  end

endmodule

`default_nettype wire

/* rtl/tcc_back.sv */
// back end: turns queued commands into draw and scroll results
// depends on tcc_pkg; holds the result register
`default_nettype none

module tcc_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire tcc_pkg::cfg_t cfg,
  input  wire logic          q_empty,
  input  wire tcc_pkg::cmd_t q_head,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output logic               out_kind,
  output logic [7:0]         out_glyph,
  output logic [12:0]        out_pixel_x,
  output logic [12:0]        out_pixel_y,
  output logic [31:0]        out_draw_fg,
  output logic [31:0]        out_draw_bg,
  output logic               out_last
);

  logic        valid_r;
  logic        phase_r, phase_nxt;
  logic        kind_r;
  logic [7:0]  glyph_r;
  logic [12:0] px_r;
  logic [12:0] py_r;
  logic [31:0] fg_r;
  logic [31:0] bg_r;
  logic        last_r;

  logic        slot_free;
  logic        issue;
  logic        do_draw;
  logic [5:0]  cw;
  logic [5:0]  ch;
  logic [13:0] px_full;
  logic [13:0] py_full;

  always_comb begin
    if (cfg.cell_width == 6'd0) cw = 6'd1;
    else if (cfg.cell_width > 6'd32) cw = 6'd32;
    else cw = cfg.cell_width;
    if (cfg.cell_height == 6'd0) ch = 6'd1;
    else if (cfg.cell_height > 6'd32) ch = 6'd32;
    else ch = cfg.cell_height;
  end

  assign px_full = {6'd0, q_head.col} * {8'd0, cw};
  assign py_full = {6'd0, q_head.row} * {8'd0, ch};

  assign slot_free = !valid_r || pop;
  assign issue     = slot_free && !q_empty;
  assign do_draw   = q_head.has_draw && !phase_r;

  // draw first, then the scroll of the same character
  always_comb begin
    q_pop     = 1'b0;
    phase_nxt = phase_r;
    if (issue) begin
      if (do_draw && q_head.has_scroll) begin
        phase_nxt = 1'b1;
      end else begin
        q_pop     = 1'b1;
        phase_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      if (issue) valid_r <= 1'b1;
      else if (pop) valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      if (do_draw) begin
        kind_r  <= tcc_pkg::KIND_DRAW;
        glyph_r <= q_head.glyph;
        px_r    <= px_full[12:0];
        py_r    <= py_full[12:0];
        fg_r    <= cfg.fg_colour;
        bg_r    <= cfg.bg_colour;
        last_r  <= !q_head.has_scroll;
      end else begin
        kind_r  <= tcc_pkg::KIND_SCROLL;
        glyph_r <= 8'd0;
        px_r    <= 13'd0;
        py_r    <= 13'd0;
        fg_r    <= 32'd0;
        bg_r    <= 32'd0;
        last_r  <= 1'b1;
      end
    end
  end

  assign empty       = !valid_r;
  assign out_kind    = kind_r;
  assign out_glyph   = glyph_r;
  assign out_pixel_x = px_r;
  assign out_pixel_y = py_r;
  assign out_draw_fg = fg_r;
  assign out_draw_bg = bg_r;
  assign out_last    = last_r;

endmodule

`default_nettype wire

/* rtl/text_console_cursor_unit.sv */
// a character is written into the command queue, then issued to the result register
// throughput: one character per cycle while the queue is not full; a character that
//   draws and scrolls gives two results, issued one per cycle while pop takes them
// reset (rst_n low, synchronous): cursor to 0,0, queue and result register empty,
//   configuration registers to their default values
`default_nettype none

module text_console_cursor_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [7:0]                      in_char_code,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic                                 out_kind,
  output logic [7:0]                           out_glyph,
  output logic [12:0]                          out_pixel_x,
  output logic [12:0]                          out_pixel_y,
  output logic [31:0]                          out_draw_fg,
  output logic [31:0]                          out_draw_bg,
  output logic                                 out_last,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [tcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [31:0]                     cfg_data
);

  tcc_pkg::cfg_t cfg_r;
  tcc_pkg::cmd_t front_cmd;
  tcc_pkg::cmd_t q_head;
  logic          front_valid;
  logic          q_empty;
  logic          q_full;
  logic          q_pop;
  logic          accept;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.columns     <= 9'd80;
      cfg_r.rows        <= 9'd25;
      cfg_r.cell_width  <= 6'd8;
      cfg_r.cell_height <= 6'd16;
      cfg_r.tab_width   <= 7'd8;
      cfg_r.fg_colour   <= 32'h00FF_FFFF;
      cfg_r.bg_colour   <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tcc_pkg::REG_COLUMNS:     cfg_r.columns     <= cfg_data[8:0];
        tcc_pkg::REG_ROWS:        cfg_r.rows        <= cfg_data[8:0];
        tcc_pkg::REG_CELL_WIDTH:  cfg_r.cell_width  <= cfg_data[5:0];
        tcc_pkg::REG_CELL_HEIGHT: cfg_r.cell_height <= cfg_data[5:0];
        tcc_pkg::REG_TAB_WIDTH:   cfg_r.tab_width   <= cfg_data[6:0];
        tcc_pkg::REG_FG_COLOUR:   cfg_r.fg_colour   <= cfg_data;
        tcc_pkg::REG_BG_COLOUR:   cfg_r.bg_colour   <= cfg_data;
        default: ;
      endcase
    end
  end

  tcc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .char_code (in_char_code),
    .cmd_valid (front_valid),
    .cmd       (front_cmd)
  );

  tcc_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (front_valid),
    .wr_data (front_cmd),
    .rd_en   (q_pop),
    .rd_data (q_head),
    .q_empty (q_empty),
    .q_full  (q_full)
  );

  tcc_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_empty     (q_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .out_kind    (out_kind),
    .out_glyph   (out_glyph),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_draw_fg (out_draw_fg),
    .out_draw_bg (out_draw_bg),
    .out_last    (out_last)
  );

endmodule

`default_nettype wire

/* rtl/tcc_checker.sv */
// port-level checks for text_console_cursor_unit, bound to the top level
// depends on tcc_pkg
`default_nettype none

module tcc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        out_kind,
  input wire logic [7:0]  out_glyph,
  input wire logic [12:0] out_pixel_x,
  input wire logic [12:0] out_pixel_y,
  input wire logic [31:0] out_draw_fg,
  input wire logic [31:0] out_draw_bg,
  input wire logic        out_last
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queue not cleared by reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_kind) && $stable(out_glyph) &&
      $stable(out_pixel_x) && $stable(out_pixel_y) && $stable(out_draw_fg) &&
      $stable(out_draw_bg) && $stable(out_last))
    else $error("waiting result changed before transfer");

  a_scroll_fields: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_kind == tcc_pkg::KIND_SCROLL |->
      out_glyph == 8'd0 && out_pixel_x == 13'd0 && out_pixel_y == 13'd0 &&
      out_draw_fg == 32'd0 && out_draw_bg == 32'd0 && out_last)
    else $error("scroll result with nonzero fields or not last");

  a_scroll_after_draw: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && pop && !out_last |=> !empty && out_kind == tcc_pkg::KIND_SCROLL)
    else $error("non-final draw not followed by its scroll");

endmodule

bind text_console_cursor_unit tcc_checker u_tcc_checker (.*);

`default_nettype wire

/* dv/tb_text_console_cursor_unit.sv */
// self-checking testbench for text_console_cursor_unit: sends character codes and
// register writes, predicts the draw and scroll commands, and checks every result transfer
// depends on rtl/tcc_pkg.sv and rtl/text_console_cursor_unit.sv
module tb_text_console_cursor_unit;

  localparam int IDLE_PCT    = 27;
  localparam int HOLD_LEN    = 300;
  localparam int SETTLE      = 16;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_PRINTS  = 40;

  localparam logic [tcc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic        kind;
    logic [7:0]  glyph;
    logic [12:0] pixel_x;
    logic [12:0] pixel_y;
    logic [31:0] fg;
    logic [31:0] bg;
    logic        last;
  } screen_cmd_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          push = 1'b0;
  logic                          full;
  logic [7:0]                    in_char_code = '0;
  logic                          empty;
  logic                          pop = 1'b0;
  logic                          out_kind;
  logic [7:0]                    out_glyph;
  logic [12:0]                   out_pixel_x;
  logic [12:0]                   out_pixel_y;
  logic [31:0]                   out_draw_fg;
  logic [31:0]                   out_draw_bg;
  logic                          out_last;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [tcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]                   cfg_data = '0;

  // console model state
  tcc_pkg::cfg_t screen;
  logic [7:0]    cur_col;
  logic [7:0]    cur_row;
  screen_cmd_t   cmd_q[$];

  int errors = 0;
  int quiet_cycles = 0;
  bit calm_in = 1'b0;
  bit calm_out = 1'b0;
  int hold_tag = 0;
  int hold_seen = 0;
  int hold_left = 0;

  text_console_cursor_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .push(push),
    .full(full),
    .in_char_code(in_char_code),
    .empty(empty),
    .pop(pop),
    .out_kind(out_kind),
    .out_glyph(out_glyph),
    .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y),
    .out_draw_fg(out_draw_fg),
    .out_draw_bg(out_draw_bg),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report(input string msg);
    if (errors < MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
    errors++;
  endtask

  function automatic int unsigned clamp_reg(int unsigned v, int unsigned lo, int unsigned hi);
    if (v < lo) return lo;
    else if (v > hi) return hi;
    else return v;
  endfunction

  task automatic reset_console();
    screen.columns = 9'd80;
    screen.rows = 9'd25;
    screen.cell_width = 6'd8;
    screen.cell_height = 6'd16;
    screen.tab_width = 7'd8;
    screen.fg_colour = 32'h00FF_FFFF;
    screen.bg_colour = 32'h0;
    cur_col = '0;
    cur_row = '0;
    cmd_q.delete();
  endtask

  task automatic apply_reg(input logic [tcc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    case (idx)
      tcc_pkg::REG_COLUMNS:     screen.columns = val[8:0];
      tcc_pkg::REG_ROWS:        screen.rows = val[8:0];
      tcc_pkg::REG_CELL_WIDTH:  screen.cell_width = val[5:0];
      tcc_pkg::REG_CELL_HEIGHT: screen.cell_height = val[5:0];
      tcc_pkg::REG_TAB_WIDTH:   screen.tab_width = val[6:0];
      tcc_pkg::REG_FG_COLOUR:   screen.fg_colour = val;
      tcc_pkg::REG_BG_COLOUR:   screen.bg_colour = val;
      default: ;
    endcase
  endtask

  // returns 1 when the new line scrolls the screen
  function automatic bit line_feed();
    int unsigned nrows;
    int unsigned next_row;
    nrows = clamp_reg(32'(screen.rows), 1, 256);
    next_row = cur_row + 1;
    cur_col = '0;
    if (next_row >= nrows) begin
      cur_row = 8'(nrows - 1);
      return 1'b1;
    end else begin
      cur_row = 8'(next_row);
      return 1'b0;
    end
  endfunction

  task automatic console_char(input logic [7:0] c);
    int unsigned ncol;
    int unsigned tw;
    int unsigned nc;
    screen_cmd_t draw;
    screen_cmd_t scroll;
    bit has_draw;
    bit has_scroll;
    ncol = clamp_reg(32'(screen.columns), 1, 256);
    has_draw = 1'b0;
    has_scroll = 1'b0;
    draw = '0;
    draw.kind = tcc_pkg::KIND_DRAW;
    draw.pixel_x = 13'(cur_col * clamp_reg(32'(screen.cell_width), 1, 32));
    draw.pixel_y = 13'(cur_row * clamp_reg(32'(screen.cell_height), 1, 32));
    draw.fg = screen.fg_colour;
    draw.bg = screen.bg_colour;
    case (c)
      tcc_pkg::CH_NL: has_scroll = line_feed();
      tcc_pkg::CH_CR: cur_col = '0;
      tcc_pkg::CH_BS: begin
        has_draw = 1'b1;
        draw.glyph = tcc_pkg::CH_SPACE;
        if (cur_col != 0) cur_col = cur_col - 8'd1;
      end
      tcc_pkg::CH_TAB: begin
        tw = clamp_reg(32'(screen.tab_width), 1, 64);
        nc = (cur_col + tw) & ~(tw - 1);
        if (nc >= ncol) has_scroll = line_feed();
        else cur_col = 8'(nc);
      end
      default: begin
        has_draw = 1'b1;
        draw.glyph = c;
        nc = cur_col + 1;
        if (nc >= ncol) has_scroll = line_feed();
        else cur_col = 8'(nc);
      end
    endcase
    if (has_draw) begin
      draw.last = !has_scroll;
      cmd_q.push_back(draw);
    end
    if (has_scroll) begin
      scroll = '0;
      scroll.kind = tcc_pkg::KIND_SCROLL;
      scroll.last = 1'b1;
      cmd_q.push_back(scroll);
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report($sformatf("%s mismatch: got 0x%0h, expected 0x%0h",
                                       name, got, want));
  endtask

  task automatic check_result();
    screen_cmd_t want;
    if (cmd_q.size() == 0) begin
      report("result transfer with nothing expected");
    end else begin
      want = cmd_q.pop_front();
      compare_field("kind", 32'(out_kind), 32'(want.kind));
      compare_field("glyph", 32'(out_glyph), 32'(want.glyph));
      compare_field("pixel_x", 32'(out_pixel_x), 32'(want.pixel_x));
      compare_field("pixel_y", 32'(out_pixel_y), 32'(want.pixel_y));
      compare_field("draw_fg", out_draw_fg, want.fg);
      compare_field("draw_bg", out_draw_bg, want.bg);
      compare_field("last", 32'(out_last), 32'(want.last));
    end
  endtask

  // transfer monitor: results first, then the new character, then register writes
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_console();
    end else begin
      if (pop && !empty) check_result();
      if (push && !full) console_char(in_char_code);
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: random pop, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_seen != hold_tag) begin
      pop <= 1'b0;
      hold_seen <= hold_tag;
      hold_left <= HOLD_LEN;
    end else begin
      pop <= calm_out || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_char(input logic [7:0] c);
    if (!calm_in && $urandom_range(99) < IDLE_PCT) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < IDLE_PCT);
    end
    push <= 1'b1;
    in_char_code <= c;
    do @(posedge clk); while (full);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    do @(posedge clk); while (cmd_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tcc_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // unused upper data bits are randomized
  task automatic set_screen(input int unsigned cols, input int unsigned nrows,
                            input int unsigned cw, input int unsigned chh,
                            input int unsigned tw, input logic [31:0] fg,
                            input logic [31:0] bg);
    write_reg(tcc_pkg::REG_COLUMNS, ($urandom() & ~32'h1FF) | (cols & 32'h1FF));
    write_reg(tcc_pkg::REG_ROWS, ($urandom() & ~32'h1FF) | (nrows & 32'h1FF));
    write_reg(tcc_pkg::REG_CELL_WIDTH, ($urandom() & ~32'h3F) | (cw & 32'h3F));
    write_reg(tcc_pkg::REG_CELL_HEIGHT, ($urandom() & ~32'h3F) | (chh & 32'h3F));
    write_reg(tcc_pkg::REG_TAB_WIDTH, ($urandom() & ~32'h7F) | (tw & 32'h7F));
    write_reg(tcc_pkg::REG_FG_COLOUR, fg);
    write_reg(tcc_pkg::REG_BG_COLOUR, bg);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_screen();
    int unsigned cols;
    int unsigned nrows;
    int unsigned cw;
    int unsigned chh;
    int unsigned tw;
    cols = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 40);
    nrows = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(1, 8);
    cw = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(1, 32);
    chh = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(1, 32);
    tw = ($urandom_range(3) == 0) ? $urandom_range(127) : (1 << $urandom_range(6));
    set_screen(cols, nrows, cw, chh, tw, $urandom(), $urandom());
  endtask

  // mostly random byte values with control codes mixed in
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return tcc_pkg::CH_NL;
    else if (r < 9) return tcc_pkg::CH_CR;
    else if (r < 13) return tcc_pkg::CH_BS;
    else if (r < 18) return tcc_pkg::CH_TAB;
    else return 8'($urandom_range(255));
  endfunction

  task automatic test_reset_defaults();
    send_char(8'd65);
    send_char(8'hFF);
    send_char(8'h00);
    send_char(tcc_pkg::CH_BS);
    send_char(tcc_pkg::CH_BS);
    send_char(tcc_pkg::CH_BS);
    send_char(tcc_pkg::CH_TAB);
    send_char(tcc_pkg::CH_CR);
    send_char(tcc_pkg::CH_NL);
    send_char(8'h7F);
  endtask

  task automatic test_small_screen();
    wait_idle();
    set_screen(4, 2, 32, 32, 2, 32'hFFFF_FFFF, 32'h0);
    send_char(tcc_pkg::CH_CR);
    send_char("x");
    send_char("y");
    send_char("z");
    send_char("w");
    send_char("a");
    send_char("b");
    send_char("c");
    send_char("d");
    send_char(tcc_pkg::CH_NL);
    send_char(tcc_pkg::CH_TAB);
    send_char(tcc_pkg::CH_TAB);
    send_char(tcc_pkg::CH_BS);
  endtask

  task automatic test_clamped_registers();
    wait_idle();
    write_reg(REG_UNUSED, $urandom());
    set_screen(0, 0, 0, 0, 0, 32'h0, 32'h0);
    repeat (30) send_char(pick_char());
    wait_idle();
    set_screen(511, 511, 63, 63, 127, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (30) send_char(pick_char());
    wait_idle();
    set_screen(256, 256, 32, 32, 64, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
    repeat (30) send_char(pick_char());
    wait_idle();
    set_screen(1, 1, 1, 1, 1, $urandom(), $urandom());
    repeat (30) send_char(pick_char());
  endtask

  task automatic test_cursor_off_screen();
    wait_idle();
    set_screen(200, 100, 5, 7, 8, $urandom(), $urandom());
    repeat (20) send_char(tcc_pkg::CH_NL);
    repeat (150) send_char(8'($urandom_range(32, 126)));
    wait_idle();
    set_screen(8, 3, 5, 7, 8, $urandom(), $urandom());
    send_char(tcc_pkg::CH_BS);
    send_char("Q");
    repeat (30) send_char(pick_char());
  endtask

  task automatic test_no_idle();
    wait_idle();
    random_screen();
    calm_in = 1'b1;
    calm_out = 1'b1;
    repeat (150) send_char(pick_char());
    calm_in = 1'b0;
    calm_out = 1'b0;
  endtask

  task automatic test_full_stall();
    wait_idle();
    random_screen();
    calm_in = 1'b1;
    hold_tag <= hold_tag + 1;
    repeat (40) send_char(8'($urandom_range(32, 126)));
    calm_in = 1'b0;
  endtask

  task automatic test_random_text();
    repeat (6) begin
      wait_idle();
      random_screen();
      repeat (110) send_char(pick_char());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_small_screen();
    test_clamped_registers();
    test_cursor_off_screen();
    test_no_idle();
    test_full_stall();
    test_random_text();
    wait_idle();
    if (errors == 0 && cmd_q.size() == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
